/* rtl/srb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sequence reorder buffer package
// Shared widths, constants and the word types passed between the front end,
// the queue and the release engine.
// ----------------------------------------------------------------------------
package srb_pkg;

  localparam int WINDOW_DEPTH_DEFAULT = 32;
  localparam int WINDOW_DEPTH_MAX     = 64;
  localparam int SLOT_MAX_W           = $clog2(WINDOW_DEPTH_MAX);

  localparam int INDEX_W   = 32;
  localparam int PAYLOAD_W = 16;
  localparam int DELAY_W   = 5;

  localparam logic [DELAY_W-1:0] MAX_DELAY_RESET = 5'd16;

  localparam int MAX_RESULTS  = 32;
  localparam int RESULT_CNT_W = $clog2(MAX_RESULTS + 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Classified word handed from the front end to the release engine
  typedef struct packed {
    logic [INDEX_W-1:0]    idx;
    logic [PAYLOAD_W-1:0]  tag;
    logic                  eob;
    logic                  in_range;
    logic [SLOT_MAX_W-1:0] slot;
  } item_t;

  // Release window as seen by the front end
  typedef struct packed {
    logic               released_any;
    logic [INDEX_W-1:0] last_released;
  } window_status_t;

endpackage
`default_nettype wire

/* rtl/sequence_reorder_buffer_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sequence reorder buffer core
// Window of WINDOW_DEPTH slots with in-order release at end of batch and a
// forced flush of the smallest held word once more than max_delay are held.
// ----------------------------------------------------------------------------
// A word without end of batch passes the capture state, then, when WINDOW_DEPTH
//   is not a power of two, the quotient and remainder states for the slot, then
//   the push state and the queue; busy stays high until the word is stored.
// With end of batch, each release decision waits for the registered minimum
//   tree; n releases take n + 1 decisions.
// Results leave one per strobe, the last flagged by run_last; the receiver
//   cannot stall. Synchronous reset clears all slots, counters and max_delay
//   (back to 16); there is no clearing pass.
module sequence_reorder_buffer_core
  import srb_pkg::*;
#(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [INDEX_W-1:0]   frame_index,
  input  wire logic [PAYLOAD_W-1:0] payload_tag,
  input  wire logic                 end_of_batch,
  input  wire logic                 cfg_we,
  input  wire logic [DELAY_W-1:0]   cfg_wdata,
  output logic                      result_valid,
  output logic [INDEX_W-1:0]        out_index,
  output logic [PAYLOAD_W-1:0]      out_payload,
  output logic                      run_last
);

  logic [DELAY_W-1:0] max_delay;
  logic               accept;
  logic               front_idle;
  logic               back_idle;
  logic               push;
  item_t              push_item;
  logic               q_full;
  logic               q_valid;
  item_t              q_item;
  logic               q_pop;
  window_status_t     status;

  assign accept = start && !busy;
  assign busy   = !front_idle || q_valid || !back_idle;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_delay <= MAX_DELAY_RESET;
    end else if (cfg_we) begin
      max_delay <= cfg_wdata;
    end
  end

  srb_front #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .frame_index  (frame_index),
    .payload_tag  (payload_tag),
    .end_of_batch (end_of_batch),
    .status       (status),
    .q_full       (q_full),
    .push         (push),
    .push_item    (push_item),
    .idle         (front_idle)
  );

  srb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_item)
  );

  srb_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .max_delay    (max_delay),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .status       (status),
    .result_valid (result_valid),
    .out_index    (out_index),
    .out_payload  (out_payload),
    .run_last     (run_last),
    .idle         (back_idle)
  );

endmodule
`default_nettype wire

/* rtl/srb_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sequence reorder buffer front end
// Captures an input word, reduces its index to a slot and checks it against
// the release window, then pushes the classified word to the queue.
// ----------------------------------------------------------------------------
module srb_front
  import srb_pkg::*;
#(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 accept,
  input  wire logic [INDEX_W-1:0]   frame_index,
  input  wire logic [PAYLOAD_W-1:0] payload_tag,
  input  wire logic                 end_of_batch,
  input  wire window_status_t       status,
  input  wire logic                 q_full,
  output logic                      push,
  output item_t                     push_item,
  output logic                      idle
);

  localparam int SLOT_W      = $clog2(WINDOW_DEPTH);
  localparam bit POW2        = (WINDOW_DEPTH & (WINDOW_DEPTH - 1)) == 0;
  localparam int HALF_W      = INDEX_W / 2;
  localparam int FOLD_W      = HALF_W + SLOT_W;
  localparam int RECIP_SHIFT = FOLD_W + SLOT_W;
  localparam int RECIP_W     = FOLD_W + 2;
  localparam int PROD_W      = FOLD_W + RECIP_W;
  localparam longint HALF_MOD = (longint'(1) << HALF_W) % WINDOW_DEPTH;
  localparam longint RECIP    =
    ((longint'(1) << RECIP_SHIFT) + WINDOW_DEPTH - 1) / WINDOW_DEPTH;

  typedef enum logic [1:0] {F_IDLE, F_QUOT, F_REM, F_PUSH} fstate_t;

  fstate_t              state;
  logic [INDEX_W-1:0]   idx;
  logic [PAYLOAD_W-1:0] tag;
  logic                 eob;
  logic [SLOT_W-1:0]    rem;
  logic [FOLD_W-1:0]    fold;
  logic [FOLD_W-1:0]    quot;

  logic [FOLD_W-1:0]    fold_next;
  logic [PROD_W-1:0]    prod;
  logic [FOLD_W-1:0]    quot_next;
  logic [FOLD_W-1:0]    rem_full;
  logic [INDEX_W-1:0]   ahead;
  logic                 in_range;

  // Fold the upper half onto the lower one, then divide by reciprocal multiply
  assign fold_next = FOLD_W'(frame_index[HALF_W-1:0]) +
                     FOLD_W'(frame_index[INDEX_W-1:HALF_W]) * FOLD_W'(HALF_MOD);
  assign prod      = PROD_W'(fold) * PROD_W'(RECIP);
  assign quot_next = FOLD_W'(prod >> RECIP_SHIFT);
  assign rem_full  = fold - quot * FOLD_W'(WINDOW_DEPTH);

  assign ahead    = idx - status.last_released - INDEX_W'(1);
  assign in_range = !status.released_any ||
                    ((idx > status.last_released) && (ahead < INDEX_W'(WINDOW_DEPTH)));

  assign push = (state == F_PUSH) && !q_full;
  assign idle = (state == F_IDLE);

  always_comb begin
    push_item          = '0;
    push_item.idx      = idx;
    push_item.tag      = tag;
    push_item.eob      = eob;
    push_item.in_range = in_range;
    push_item.slot     = SLOT_MAX_W'(rem);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (accept) begin
            idx <= frame_index;
            tag <= payload_tag;
            eob <= end_of_batch;
            if (POW2) begin
              rem   <= frame_index[SLOT_W-1:0];
              state <= F_PUSH;
            end else begin
              fold  <= fold_next;
              state <= F_QUOT;
            end
          end
        end
        F_QUOT: begin
          quot  <= quot_next;
          state <= F_REM;
        end
        F_REM: begin
          rem   <= rem_full[SLOT_W-1:0];
          state <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/srb_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sequence reorder buffer queue
// Short FIFO of classified words between the front end and release engine.
// ----------------------------------------------------------------------------
module srb_queue
  import srb_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire item_t push_item,
  output logic       full,
  input  wire logic  pop,
  output logic       valid,
  output item_t      head
);

  item_t                  entry [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic                   do_push;
  logic                   do_pop;

  assign full    = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign valid   = (count != '0);
  assign head    = entry[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QUEUE_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QUEUE_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QUEUE_CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/srb_min_tree.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sequence reorder buffer minimum tree
// Registered compare tree that finds the held slot with the smallest index,
// one register level per tree level.
// ----------------------------------------------------------------------------
module srb_min_tree
  import srb_pkg::*;
#(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEFAULT
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic [WINDOW_DEPTH-1:0]  leaf_valid,
  input  wire logic [INDEX_W-1:0]       leaf_index [WINDOW_DEPTH],
  output logic                          min_valid,
  output logic [INDEX_W-1:0]            min_index,
  output logic [$clog2(WINDOW_DEPTH)-1:0] min_slot
);

  localparam int SLOT_W = $clog2(WINDOW_DEPTH);
  localparam int LEVELS = $clog2(WINDOW_DEPTH);
  localparam int LEAVES = 1 << LEVELS;

  typedef struct packed {
    logic               valid;
    logic [INDEX_W-1:0] index;
    logic [SLOT_W-1:0]  slot;
  } node_t;

  node_t leaf  [LEAVES];
  node_t inner [1:LEAVES-1];

  for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
    if (i < WINDOW_DEPTH) begin : g_used
      assign leaf[i] = '{valid: leaf_valid[i], index: leaf_index[i], slot: SLOT_W'(i)};
    end else begin : g_pad
      assign leaf[i] = '0;
    end
  end

  for (genvar i = 1; i < LEAVES; i++) begin : g_node
    node_t a;
    node_t b;
    if (2 * i >= LEAVES) begin : g_from_leaf
      assign a = leaf[2 * i - LEAVES];
      assign b = leaf[2 * i + 1 - LEAVES];
    end else begin : g_from_inner
      assign a = inner[2 * i];
      assign b = inner[2 * i + 1];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        inner[i] <= '0;
      end else if (a.valid && (!b.valid || a.index < b.index)) begin
        inner[i] <= a;
      end else begin
        inner[i] <= b;
      end
    end
  end

  assign min_valid = inner[1].valid;
  assign min_index = inner[1].index;
  assign min_slot  = inner[1].slot;

endmodule
`default_nettype wire

/* rtl/srb_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sequence reorder buffer release engine
// Holds the slot window, stores classified words and, at end of batch,
// releases held words in index order, forcing out the smallest when too many
// are held.
// ----------------------------------------------------------------------------
module srb_back
  import srb_pkg::*;
#(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [DELAY_W-1:0]   max_delay,
  input  wire logic                 q_valid,
  input  wire item_t                q_item,
  output logic                      q_pop,
  output window_status_t            status,
  output logic                      result_valid,
  output logic [INDEX_W-1:0]        out_index,
  output logic [PAYLOAD_W-1:0]      out_payload,
  output logic                      run_last,
  output logic                      idle
);

  localparam int SLOT_W      = $clog2(WINDOW_DEPTH);
  localparam int LEVELS      = $clog2(WINDOW_DEPTH);
  localparam int HELD_W      = $clog2(WINDOW_DEPTH + 1);
  localparam int WAIT_CYCLES = LEVELS + 1;
  localparam int WAIT_W      = $clog2(WAIT_CYCLES + 1);

  typedef enum logic {B_IDLE, B_SEARCH} bstate_t;

  // Slot window
  logic [WINDOW_DEPTH-1:0] slot_valid;
  logic [INDEX_W-1:0]      slot_index   [WINDOW_DEPTH];
  logic [PAYLOAD_W-1:0]    slot_payload [WINDOW_DEPTH];
  logic [PAYLOAD_W-1:0]    pay_rd;

  bstate_t                 state;
  logic [WAIT_W-1:0]       wait_cnt;
  logic [RESULT_CNT_W-1:0] rel_count;
  logic [HELD_W-1:0]       held_count;
  logic [INDEX_W-1:0]      last_released;
  logic                    released_any;
  logic                    pend_valid;
  logic [INDEX_W-1:0]      pend_index;
  logic [PAYLOAD_W-1:0]    pend_payload;

  logic                    min_valid;
  logic [INDEX_W-1:0]      min_index;
  logic [SLOT_W-1:0]       min_slot;

  logic [SLOT_W-1:0]       q_slot;
  logic                    hit_valid;
  logic                    hit_match;
  logic                    store_en;
  logic                    insert_en;
  logic                    decide;
  logic                    go_cond;
  logic                    release_en;

  srb_min_tree #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_min_tree (
    .clk        (clk),
    .rst        (rst),
    .leaf_valid (slot_valid),
    .leaf_index (slot_index),
    .min_valid  (min_valid),
    .min_index  (min_index),
    .min_slot   (min_slot)
  );

  assign q_slot    = q_item.slot[SLOT_W-1:0];
  assign hit_valid = slot_valid[q_slot];
  assign hit_match = (slot_index[q_slot] == q_item.idx);
  assign q_pop     = (state == B_IDLE) && q_valid;

  // Drop on collision; a rewrite of the same index replaces only the payload
  assign store_en  = q_pop && q_item.in_range && (!hit_valid || hit_match);
  assign insert_en = q_pop && q_item.in_range && !hit_valid;

  assign decide  = (state == B_SEARCH) && (wait_cnt == '0);
  always_comb begin
    if (8'(held_count) > 8'(max_delay)) begin
      go_cond = 1'b1;
    end else if (released_any) begin
      go_cond = (min_index == last_released + INDEX_W'(1));
    end else begin
      go_cond = (min_index <= INDEX_W'(1));
    end
  end
  assign release_en = decide && min_valid && go_cond &&
                      (rel_count != RESULT_CNT_W'(MAX_RESULTS));

  assign status = '{released_any: released_any, last_released: last_released};
  assign idle   = (state == B_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else begin
      if (insert_en) begin
        slot_valid[q_slot] <= 1'b1;
      end
      if (release_en) begin
        slot_valid[min_slot] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (insert_en) begin
      slot_index[q_slot] <= q_item.idx;
    end
  end

  always_ff @(posedge clk) begin
    if (store_en) begin
      slot_payload[q_slot] <= q_item.tag;
    end
    pay_rd <= slot_payload[min_slot];
  end

  // A release is held back one decision so the last one of a run can be flagged
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= B_IDLE;
      wait_cnt      <= '0;
      rel_count     <= '0;
      held_count    <= '0;
      last_released <= '0;
      released_any  <= 1'b0;
      pend_valid    <= 1'b0;
      result_valid  <= 1'b0;
      run_last      <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      run_last     <= 1'b0;
      case (state)
        B_IDLE: begin
          if (q_pop) begin
            if (insert_en) begin
              held_count <= held_count + HELD_W'(1);
            end
            if (q_item.eob) begin
              state      <= B_SEARCH;
              wait_cnt   <= WAIT_W'(WAIT_CYCLES);
              rel_count  <= '0;
              pend_valid <= 1'b0;
            end
          end
        end
        B_SEARCH: begin
          if (wait_cnt != '0) begin
            wait_cnt <= wait_cnt - WAIT_W'(1);
          end else if (release_en) begin
            if (pend_valid) begin
              result_valid <= 1'b1;
              out_index    <= pend_index;
              out_payload  <= pend_payload;
            end
            pend_valid    <= 1'b1;
            pend_index    <= min_index;
            pend_payload  <= pay_rd;
            held_count    <= held_count - HELD_W'(1);
            last_released <= min_index;
            released_any  <= 1'b1;
            rel_count     <= rel_count + RESULT_CNT_W'(1);
            wait_cnt      <= WAIT_W'(WAIT_CYCLES);
          end else begin
            if (pend_valid) begin
              result_valid <= 1'b1;
              run_last     <= 1'b1;
              out_index    <= pend_index;
              out_payload  <= pend_payload;
            end
            pend_valid <= 1'b0;
            state      <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/srb_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sequence reorder buffer port checker
// Port-level properties of the command handshake and result strobes.
// ----------------------------------------------------------------------------
module srb_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic result_valid,
  input wire logic run_last
);

  // Accepted word keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy low right after an accepted word");

  // A result that is not the last of its run leaves the block still working
  a_mid_run_busy: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !run_last) |-> busy)
    else $error("mid-run result while idle");

  // Nothing follows the last result of a run directly
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    (result_valid && run_last) |=> !result_valid)
    else $error("result right after run end");

  // Out of reset: idle and quiet
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> (!busy && !result_valid))
    else $error("activity right after reset");

endmodule

bind sequence_reorder_buffer_core srb_checker u_srb_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid),
  .run_last     (run_last)
);
`default_nettype wire

/* dv/srb_release_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sequence reorder buffer release checker
// Watches the command and release channels of the core. It keeps its own
// copy of the slot window, predicts the released words for every accepted
// input word and compares each strobed release against the oldest one due.
// ----------------------------------------------------------------------------
module srb_release_checker
  import srb_pkg::*;
#(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic                 busy,
  input  wire logic [INDEX_W-1:0]   frame_index,
  input  wire logic [PAYLOAD_W-1:0] payload_tag,
  input  wire logic                 end_of_batch,
  input  wire logic                 cfg_we,
  input  wire logic [DELAY_W-1:0]   cfg_wdata,
  input  wire logic                 result_valid,
  input  wire logic [INDEX_W-1:0]   out_index,
  input  wire logic [PAYLOAD_W-1:0] out_payload,
  input  wire logic                 run_last,
  output int                        fail_count,
  output int                        pending,
  output int                        checked
);

  typedef struct packed {
    logic [INDEX_W-1:0]   idx;
    logic [PAYLOAD_W-1:0] tag;
    logic                 last;
  } release_t;

  release_t             due_q[$];
  release_t             due;

  logic [PAYLOAD_W-1:0] held_tag [WINDOW_DEPTH];
  logic [INDEX_W-1:0]   held_idx [WINDOW_DEPTH];
  logic                 held_vld [WINDOW_DEPTH];
  logic [INDEX_W-1:0]   last_out;
  logic                 any_out;
  int unsigned          held_n;
  logic [DELAY_W-1:0]   delay_limit;

  task automatic report_mismatch(input string what, input logic [INDEX_W-1:0] want,
                                 input logic [INDEX_W-1:0] got);
    $display("mismatch at %0t: %s expected %0h got %0h", $realtime, what, want, got);
    fail_count++;
  endtask

  // Store one word in the window, then on end of batch work out the releases.
  task automatic predict_word(input logic [INDEX_W-1:0] idx,
                              input logic [PAYLOAD_W-1:0] tag, input logic eob);
    logic [INDEX_W-1:0] ahead;
    logic               keep;
    logic               go;
    int                 slot;
    int                 best;
    int                 n;
    int                 i;
    release_t           r;
    keep = 1'b1;
    if (any_out) begin
      ahead = idx - last_out - 1'b1;
      // drop old words and words beyond the window
      if (idx <= last_out || ahead >= INDEX_W'(WINDOW_DEPTH))
        keep = 1'b0;
    end
    slot = int'(idx % INDEX_W'(WINDOW_DEPTH));
    if (keep) begin
      if (held_vld[slot]) begin
        // same index rewrites the payload, a different one is a collision
        if (held_idx[slot] == idx)
          held_tag[slot] = tag;
      end else begin
        held_vld[slot] = 1'b1;
        held_idx[slot] = idx;
        held_tag[slot] = tag;
        held_n++;
      end
    end
    if (eob) begin
      n = 0;
      while (n < MAX_RESULTS) begin
        best = -1;
        for (i = 0; i < WINDOW_DEPTH; i++)
          if (held_vld[i] && (best < 0 || held_idx[i] < held_idx[best]))
            best = i;
        if (best < 0)
          break;
        if (held_n > delay_limit)
          go = 1'b1;
        else if (any_out)
          go = (held_idx[best] == last_out + 1'b1);
        else
          go = (held_idx[best] == '0 || held_idx[best] == INDEX_W'(1));
        if (!go)
          break;
        r.idx  = held_idx[best];
        r.tag  = held_tag[best];
        r.last = 1'b0;
        due_q.push_back(r);
        held_vld[best] = 1'b0;
        held_n--;
        last_out = held_idx[best];
        any_out  = 1'b1;
        n++;
      end
      if (n > 0) begin
        r = due_q.pop_back();
        r.last = 1'b1;
        due_q.push_back(r);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      due_q.delete();
      for (int i = 0; i < WINDOW_DEPTH; i++)
        held_vld[i] = 1'b0;
      last_out    = '0;
      any_out     = 1'b0;
      held_n      = 0;
      delay_limit = MAX_DELAY_RESET;
      fail_count  = 0;
      checked     = 0;
    end else begin
      if (result_valid) begin
        if (due_q.size() == 0) begin
          report_mismatch("release with none due, out_index", '0, out_index);
        end else begin
          due = due_q.pop_front();
          checked++;
          if (out_index !== due.idx)
            report_mismatch("out_index", due.idx, out_index);
          if (out_payload !== due.tag)
            report_mismatch("out_payload", INDEX_W'(due.tag), INDEX_W'(out_payload));
          if (run_last !== due.last)
            report_mismatch("run_last", INDEX_W'(due.last), INDEX_W'(run_last));
        end
      end
      if (cfg_we)
        delay_limit = cfg_wdata;
      if (start && !busy)
        predict_word(frame_index, payload_tag, end_of_batch);
    end
    pending = due_q.size();
  end

endmodule

/* dv/tb_sequence_reorder_buffer_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sequence reorder buffer core testbench
// Drives directed and randomized batches of sequence-numbered words through
// the core under several max_delay settings; the release checker beside the
// core predicts and compares every released word.
// ----------------------------------------------------------------------------
module tb_sequence_reorder_buffer_core;
  import srb_pkg::*;

  localparam int DEPTH         = WINDOW_DEPTH_DEFAULT;
  localparam int DECIDE_CYCLES = $clog2(DEPTH) + 2;
  localparam int SETTLE_CYCLES = 2 * DECIDE_CYCLES;
  localparam int STALL_LIMIT   = 400;
  localparam int TOTAL_WORDS   = 260;

  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 start        = 1'b0;
  logic                 busy;
  logic [INDEX_W-1:0]   frame_index  = '0;
  logic [PAYLOAD_W-1:0] payload_tag  = '0;
  logic                 end_of_batch = 1'b0;
  logic                 cfg_we       = 1'b0;
  logic [DELAY_W-1:0]   cfg_wdata    = '0;
  logic                 result_valid;
  logic [INDEX_W-1:0]   out_index;
  logic [PAYLOAD_W-1:0] out_payload;
  logic                 run_last;

  int                   fail_count;
  int                   pending;
  int                   checked;

  int                   words_sent = 0;
  int                   settings   = 0;
  int                   stall_cnt  = 0;
  bit                   no_gap     = 1'b0;
  logic [INDEX_W-1:0]   cursor;
  logic [INDEX_W-1:0]   late_q[$];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  sequence_reorder_buffer_core #(
    .WINDOW_DEPTH (DEPTH)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .frame_index  (frame_index),
    .payload_tag  (payload_tag),
    .end_of_batch (end_of_batch),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .result_valid (result_valid),
    .out_index    (out_index),
    .out_payload  (out_payload),
    .run_last     (run_last)
  );

  srb_release_checker #(
    .WINDOW_DEPTH (DEPTH)
  ) u_release_check (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .frame_index  (frame_index),
    .payload_tag  (payload_tag),
    .end_of_batch (end_of_batch),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .result_valid (result_valid),
    .out_index    (out_index),
    .out_payload  (out_payload),
    .run_last     (run_last),
    .fail_count   (fail_count),
    .pending      (pending),
    .checked      (checked)
  );

  // Abort when neither channel nor the register port moves for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || cfg_we)
      stall_cnt <= 0;
    else
      stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  // Present one word and hold it until the core takes it; start stays high.
  task automatic send_word(input logic [INDEX_W-1:0] idx,
                           input logic [PAYLOAD_W-1:0] tag, input logic eob);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 5);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start        <= 1'b1;
    frame_index  <= idx;
    payload_tag  <= tag;
    end_of_batch <= eob;
    do begin
      @(posedge clk);
    end while (busy);
    words_sent++;
  endtask

  // Drop start, then hold until every due release is out and the core is idle.
  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0 || busy)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_delay(input logic [DELAY_W-1:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    settings++;
  endtask

  // One batch of consecutive indices from the cursor, with skips held back for
  // later batches, rewrites, stale or wild noise, and most often a shuffled order.
  task automatic send_batch(input int size);
    logic [INDEX_W-1:0] order[$];
    logic [INDEX_W-1:0] tmp;
    logic               eob;
    bit                 close_batch;
    int                 i;
    int                 j;
    for (i = 0; i < size; i++) begin
      if (size > 1 && $urandom_range(0, 7) == 0)
        late_q.push_back(cursor + INDEX_W'(i));
      else
        order.push_back(cursor + INDEX_W'(i));
      if ($urandom_range(0, 9) == 0)
        order.push_back(cursor + INDEX_W'(i));
    end
    while (late_q.size() > 0 && $urandom_range(0, 2) != 0)
      order.push_back(late_q.pop_front());
    if (late_q.size() > 8)
      void'(late_q.pop_front());
    if ($urandom_range(0, 5) == 0)
      order.push_back($urandom_range(0, 1) ? INDEX_W'($urandom)
                                           : cursor - INDEX_W'($urandom_range(1, 40)));
    if ($urandom_range(0, 2) != 0) begin
      for (i = order.size() - 1; i > 0; i--) begin
        j        = $urandom_range(0, i);
        tmp      = order[i];
        order[i] = order[j];
        order[j] = tmp;
      end
    end
    close_batch = ($urandom_range(0, 9) != 0);
    for (i = 0; i < order.size(); i++) begin
      if (i == order.size() - 1)
        eob = close_batch;
      else
        eob = ($urandom_range(0, 11) == 0);
      send_word(order[i], PAYLOAD_W'($urandom), eob);
    end
    cursor = cursor + INDEX_W'(size);
  endtask

  initial begin
    int                 target;
    int                 size;
    logic [DELAY_W-1:0] setting;

    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // Before any release: park 40, collide on its slot with 8, then start at 1.
    send_word(32'd40, PAYLOAD_W'($urandom), 1'b0);
    send_word(32'd8, PAYLOAD_W'($urandom), 1'b0);
    send_word(32'd2, 16'h0000, 1'b1);
    send_word(32'd1, 16'hFFFF, 1'b1);
    // rewrite of a held slot, then release in order
    send_word(32'd4, PAYLOAD_W'($urandom), 1'b0);
    send_word(32'd4, PAYLOAD_W'($urandom), 1'b0);
    send_word(32'd3, PAYLOAD_W'($urandom), 1'b1);
    // stale, already released and beyond-window words
    send_word(32'd4, PAYLOAD_W'($urandom), 1'b1);
    send_word(32'd0, PAYLOAD_W'($urandom), 1'b1);
    send_word(32'd37, PAYLOAD_W'($urandom), 1'b1);
    send_word(32'hFFFF_FFFF, 16'hFFFF, 1'b1);
    send_word(32'hAAAA_AAAA, PAYLOAD_W'($urandom), 1'b0);
    send_word(32'h5555_5555, PAYLOAD_W'($urandom), 1'b0);
    // far edge of the window stays held behind the gap
    send_word(32'd5, PAYLOAD_W'($urandom), 1'b0);
    send_word(32'd36, PAYLOAD_W'($urandom), 1'b0);
    send_word(32'd6, PAYLOAD_W'($urandom), 1'b1);

    // small delay limit: force out past the missing 7 and 8, which then come too late and are dropped
    write_delay(5'd2);
    send_word(32'd9, PAYLOAD_W'($urandom), 1'b0);
    send_word(32'd10, PAYLOAD_W'($urandom), 1'b0);
    send_word(32'd11, PAYLOAD_W'($urandom), 1'b1);
    send_word(32'd7, PAYLOAD_W'($urandom), 1'b0);
    send_word(32'd8, PAYLOAD_W'($urandom), 1'b1);

    // zero limit flushes everything held
    write_delay(5'd0);
    send_word(32'd13, PAYLOAD_W'($urandom), 1'b1);
    cursor = 32'd41;

    while (words_sent < TOTAL_WORDS) begin
      case (settings)
        2:       setting = 5'd31;
        3:       setting = 5'd0;
        default: setting = DELAY_W'($urandom_range(0, 31));
      endcase
      write_delay(setting);
      no_gap = ($urandom_range(0, 2) == 0);
      target = words_sent + $urandom_range(20, 45);
      while (words_sent < target) begin
        size = ($urandom_range(0, 11) == 0) ? DEPTH : $urandom_range(1, 8);
        send_batch(size);
        if ($urandom_range(0, 19) == 0)
          wait_drained();
      end
    end

    wait_drained();
    $display("summary: %0d words sent under %0d max_delay settings (0, 2, 31, random)",
             words_sent, settings + 1);
    $display("summary: %0d released words checked against prediction", checked);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

/* sim.f */
rtl/srb_pkg.sv
rtl/srb_front.sv
rtl/srb_queue.sv
rtl/srb_min_tree.sv
rtl/srb_back.sv
rtl/sequence_reorder_buffer_core.sv
rtl/srb_checker.sv
dv/srb_release_checker.sv
dv/tb_sequence_reorder_buffer_core.sv
